/* rtl/lota_pkg.sv */
`timescale 1ns / 1ps

package lota_pkg;

	// field widths
	localparam int LEN_W     = 8;
	localparam int BW_W      = 9;
	localparam int SF_W      = 4;
	localparam int CR_W      = 4;
	localparam int PRE_W     = 16;
	localparam int CFG_W     = 16;
	localparam int AIR_W     = 29;

	// divider cell geometry: shared working word, remainder as wide as the divisor
	localparam int WORD_W    = AIR_W;
	localparam int REM_W     = BW_W;
	localparam int BLK_NUM_W = 10;
	// up to 172 blocks at sf 5 with low rate opt
	localparam int BLK_W     = 9;
	localparam int BLK_STEPS = BLK_NUM_W;
	localparam int AIR_STEPS = WORD_W;

	// quarter-symbol count width
	localparam int QTR_W     = 19;

	// limits and fixed terms
	localparam logic [SF_W-1:0] SF_MIN  = 4'd5;
	localparam logic [SF_W-1:0] SF_MAX  = 4'd12;
	localparam logic [CR_W-1:0] CR_MIN  = 4'd5;
	localparam logic [CR_W-1:0] CR_MAX  = 4'd8;
	localparam logic [SF_W-1:0] LDO_SUB = 4'd2;
	localparam logic [SF_W-1:0] QTR_SH  = 4'd2;
	localparam logic [BLK_NUM_W-1:0] LEN_BIAS = 10'd11;
	// 17 quarters of sync/header plus 4 * 8 fixed payload symbols
	localparam logic [QTR_W-1:0] QTR_FIXED = 19'd49;

	// reset values
	localparam logic [BW_W-1:0]  BW_RST  = 9'd125;
	localparam logic [SF_W-1:0]  SF_RST  = 4'd12;
	localparam logic [CR_W-1:0]  CR_RST  = 4'd5;
	localparam logic [PRE_W-1:0] PRE_RST = 16'd8;

	typedef enum logic [1:0] {
		REG_BW  = 2'd0,
		REG_SF  = 2'd1,
		REG_CR  = 2'd2,
		REG_PRE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [BW_W-1:0]  bw;
		logic [SF_W-1:0]  sf;
		logic [CR_W-1:0]  cr;
		logic [PRE_W-1:0] pre;
	} cfg_t;

	// per-word context carried down the chain
	typedef struct packed {
		logic             ldo;
		logic [SF_W-1:0]  sf;
		logic [CR_W-1:0]  cr;
		logic [PRE_W-1:0] pre;
		logic [BW_W-1:0]  bw;
	} ctx_t;

	// state held in one divider cell
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [REM_W-1:0]  rem;
		logic [REM_W-1:0]  dsr;
		ctx_t              ctx;
	} div_t;

endpackage

/* rtl/lota_in_if.sv */
`timescale 1ns / 1ps

interface lota_in_if;
	logic                       valid;
	logic                       ready;
	logic [lota_pkg::LEN_W-1:0] payload_bytes;

	modport source (output valid, output payload_bytes, input ready);
	modport sink (input valid, input payload_bytes, output ready);
endinterface

/* rtl/lota_out_if.sv */
`timescale 1ns / 1ps

interface lota_out_if;
	logic                       valid;
	logic                       ready;
	logic [lota_pkg::AIR_W-1:0] airtime_ms;
	logic                       low_rate_opt;

	modport source (output valid, output airtime_ms, output low_rate_opt, input ready);
	modport sink (input valid, input airtime_ms, input low_rate_opt, output ready);
endinterface

/* rtl/lota_div_cell.sv */
`timescale 1ns / 1ps

module lota_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           prev_v,
	input  lota_pkg::div_t prev,
	output logic           v_q,
	output lota_pkg::div_t data_q
);

	logic [lota_pkg::REM_W:0]   shl;
	logic [lota_pkg::REM_W+1:0] diff;
	logic                       qbit;
	lota_pkg::div_t             nxt;

	// one restoring step: bring in the next dividend bit, try the subtract
	always_comb begin
		shl      = {prev.rem, prev.word[lota_pkg::WORD_W-1]};
		diff     = {1'b0, shl} - {2'b0, prev.dsr};
		qbit     = ~diff[lota_pkg::REM_W+1];
		nxt      = prev;
		nxt.rem  = qbit ? diff[lota_pkg::REM_W-1:0] : shl[lota_pkg::REM_W-1:0];
		nxt.word = {prev.word[lota_pkg::WORD_W-2:0], qbit};
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= prev_v;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

/* rtl/lota_front.sv */
`timescale 1ns / 1ps

module lota_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_v,
	input  logic [lota_pkg::LEN_W-1:0] len,
	input  lota_pkg::cfg_t             cfg,
	output logic                       v_s1,
	output lota_pkg::div_t             data_s1
);

	logic [lota_pkg::BW_W-1:0]      bw;
	logic [lota_pkg::SF_W-1:0]      sf;
	logic [lota_pkg::CR_W-1:0]      cr;
	logic [12:0]                    chips;
	logic [12:0]                    bw16;
	logic                           ldo;
	logic [lota_pkg::SF_W-1:0]      dvs;
	logic [lota_pkg::BLK_NUM_W-1:0] sum;
	logic [lota_pkg::BLK_NUM_W-1:0] num;
	lota_pkg::div_t                 nxt;

	// clamp config, decide low data rate mode, set up the ceiling division
	always_comb begin
		bw = (cfg.bw == '0) ? {{(lota_pkg::BW_W-1){1'b0}}, 1'b1} : cfg.bw;
		if (cfg.sf < lota_pkg::SF_MIN) begin
			sf = lota_pkg::SF_MIN;
		end else if (cfg.sf > lota_pkg::SF_MAX) begin
			sf = lota_pkg::SF_MAX;
		end else begin
			sf = cfg.sf;
		end
		if (cfg.cr < lota_pkg::CR_MIN) begin
			cr = lota_pkg::CR_MIN;
		end else if (cfg.cr > lota_pkg::CR_MAX) begin
			cr = lota_pkg::CR_MAX;
		end else begin
			cr = cfg.cr;
		end
		chips = 13'd1 << sf;
		bw16  = {bw, 4'b0};
		ldo   = chips > bw16;
		dvs   = ldo ? (sf - lota_pkg::LDO_SUB) : sf;
		// common factor 4 dropped: n = 2*len + 11 - sf over d = sf - 2*ldo
		sum   = {1'b0, len, 1'b0} + lota_pkg::LEN_BIAS;
		if (sum > {6'b0, sf}) begin
			num = sum - {6'b0, sf} + {6'b0, dvs} - 10'd1;
		end else begin
			num = '0;
		end
		nxt.word = {num, {(lota_pkg::WORD_W-lota_pkg::BLK_NUM_W){1'b0}}};
		nxt.rem  = '0;
		nxt.dsr  = {5'b0, dvs};
		nxt.ctx  = '{ldo: ldo, sf: sf, cr: cr, pre: cfg.pre, bw: bw};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

/* rtl/lota_scale.sv */
`timescale 1ns / 1ps

module lota_scale (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           prev_v,
	input  lota_pkg::div_t prev,
	output logic           v_q,
	output lota_pkg::div_t data_q
);

	logic [lota_pkg::BLK_W-1:0]  blk;
	logic [11:0]                 prod;
	logic [lota_pkg::QTR_W-1:0]  qtr;
	logic [lota_pkg::SF_W-1:0]   sh;
	lota_pkg::div_t              nxt;

	// quarter symbols, then scale by 2^sf / 4 ready for the bandwidth divide
	always_comb begin
		blk  = prev.word[lota_pkg::BLK_W-1:0];
		prod = {3'b0, blk} * {8'b0, prev.ctx.cr};
		qtr  = {1'b0, prev.ctx.pre, 2'b0} + lota_pkg::QTR_FIXED + {5'b0, prod, 2'b0};
		sh   = prev.ctx.sf - lota_pkg::QTR_SH;
		nxt.word = {{(lota_pkg::WORD_W-lota_pkg::QTR_W){1'b0}}, qtr} << sh;
		nxt.rem  = '0;
		nxt.dsr  = prev.ctx.bw;
		nxt.ctx  = prev.ctx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= prev_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

/* rtl/lota_time_on_air_core.sv */
`timescale 1ns / 1ps

// channel      | dir | payload                      | notes
// length_ch    | in  | payload_bytes[7:0]           | one packet length per word
// airtime_ch   | out | airtime_ms[28:0], low_rate_opt | one result per length word
// cfg_*        | in  | cfg_index[1:0], cfg_data[15:0] | write on cfg_we, no read-back
//
// one word per cycle while results are taken; one setup stage, 10 cells of
// the symbol-block divider, one scaling stage with the 9x4 multiply, 29 cells of
// the bandwidth divider (one quotient bit per cell).
// reset puts the registers at 125 kHz, sf 12, cr 4/5, 8 preamble symbols.
// while a result word waits, the whole chain holds; the setup stage still takes
// a new word when it is empty.

module lora_time_on_air_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [lota_pkg::CFG_W-1:0] cfg_data,
	lota_in_if.sink                    length_ch,
	lota_out_if.source                 airtime_ch
);

	lota_pkg::cfg_t cfg_q;
	logic           en;
	logic           front_en;

	logic           c1_v [0:lota_pkg::BLK_STEPS];
	lota_pkg::div_t c1   [0:lota_pkg::BLK_STEPS];
	logic           c2_v [0:lota_pkg::AIR_STEPS];
	lota_pkg::div_t c2   [0:lota_pkg::AIR_STEPS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{bw: lota_pkg::BW_RST, sf: lota_pkg::SF_RST,
			           cr: lota_pkg::CR_RST, pre: lota_pkg::PRE_RST};
		end else if (cfg_we) begin
			unique case (lota_pkg::reg_idx_t'(cfg_index))
				lota_pkg::REG_BW:  cfg_q.bw  <= cfg_data[lota_pkg::BW_W-1:0];
				lota_pkg::REG_SF:  cfg_q.sf  <= cfg_data[lota_pkg::SF_W-1:0];
				lota_pkg::REG_CR:  cfg_q.cr  <= cfg_data[lota_pkg::CR_W-1:0];
				lota_pkg::REG_PRE: cfg_q.pre <= cfg_data[lota_pkg::PRE_W-1:0];
				default:           cfg_q     <= cfg_q;
			endcase
		end
	end

	// chain advances unless the result word is stuck
	assign en       = ~airtime_ch.valid | airtime_ch.ready;
	assign front_en = en | ~c1_v[0];
	assign length_ch.ready = front_en;

	// setup stage
	lota_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (front_en),
		.in_v    (length_ch.valid),
		.len     (length_ch.payload_bytes),
		.cfg     (cfg_q),
		.v_s1    (c1_v[0]),
		.data_s1 (c1[0])
	);

	// symbol-block divider cells
	for (genvar k = 0; k < lota_pkg::BLK_STEPS; k++) begin : g_blk
		lota_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prev_v (c1_v[k]),
			.prev   (c1[k]),
			.v_q    (c1_v[k+1]),
			.data_q (c1[k+1])
		);
	end

	// quarter-symbol count and scaling
	lota_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.prev_v (c1_v[lota_pkg::BLK_STEPS]),
		.prev   (c1[lota_pkg::BLK_STEPS]),
		.v_q    (c2_v[0]),
		.data_q (c2[0])
	);

	// bandwidth divider cells
	for (genvar k = 0; k < lota_pkg::AIR_STEPS; k++) begin : g_air
		lota_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prev_v (c2_v[k]),
			.prev   (c2[k]),
			.v_q    (c2_v[k+1]),
			.data_q (c2[k+1])
		);
	end

	// last cell is the output register
	assign airtime_ch.valid        = c2_v[lota_pkg::AIR_STEPS];
	assign airtime_ch.airtime_ms   = c2[lota_pkg::AIR_STEPS].word;
	assign airtime_ch.low_rate_opt = c2[lota_pkg::AIR_STEPS].ctx.ldo;

endmodule
